// ===== rtl/zwac_pkg.sv =====
// Package for the zoom window address control: key codes, event codes and scaling constants.
`default_nettype none

package zwac_pkg;

  // Screen and window geometry in pixels.
  localparam int unsigned ScreenWidth  = 640;
  localparam int unsigned ScreenHeight = 480;
  localparam int unsigned WindowWidth  = 128;
  localparam int unsigned WindowHeight = 96;

  // Field widths fixed by the item formats.
  localparam int unsigned CodeW  = 10;
  localparam int unsigned ValueW = 2;
  localparam int unsigned XW     = 10;
  localparam int unsigned YW     = 9;
  localparam int unsigned StepW  = 8;

  // Pan range of the window origin, saturated at zero.
  localparam int unsigned MaxX = (ScreenWidth > WindowWidth) ? ScreenWidth - WindowWidth : 0;
  localparam int unsigned MaxY = (ScreenHeight > WindowHeight) ? ScreenHeight - WindowHeight : 0;
  localparam int unsigned CentreX = MaxX / 2;
  localparam int unsigned CentreY = MaxY / 2;

  // out * WindowSize / ScreenSize is taken as (out * K) >> S, where
  // K = WindowSize * ceil(2^S / ScreenSize). S is chosen so that the
  // reciprocal error stays below one unit of the quotient for every product.
  localparam int unsigned ProdXW = XW + $clog2(WindowWidth + 1);
  localparam int unsigned ProdYW = YW + $clog2(WindowHeight + 1);
  localparam int unsigned ShiftX = ProdXW + $clog2(ScreenWidth);
  localparam int unsigned ShiftY = ProdYW + $clog2(ScreenHeight);
  localparam longint unsigned RecipX =
    ((64'd1 << ShiftX) + 64'(ScreenWidth) - 64'd1) / 64'(ScreenWidth);
  localparam longint unsigned RecipY =
    ((64'd1 << ShiftY) + 64'(ScreenHeight) - 64'd1) / 64'(ScreenHeight);
  localparam longint unsigned ScaleX = RecipX * 64'(WindowWidth);
  localparam longint unsigned ScaleY = RecipY * 64'(WindowHeight);
  localparam int unsigned ScaleXW = $clog2(ScaleX + 64'd1);
  localparam int unsigned ScaleYW = $clog2(ScaleY + 64'd1);

  // Width of the window-plus-offset sums before clamping.
  localparam int unsigned SumW = 20;

  // Key codes and key values.
  localparam logic [CodeW-1:0]  KeyMenu  = 10'd1;
  localparam logic [CodeW-1:0]  KeyL1    = 10'd18;
  localparam logic [CodeW-1:0]  KeyUp    = 10'd103;
  localparam logic [CodeW-1:0]  KeyDown  = 10'd108;
  localparam logic [CodeW-1:0]  KeyLeft  = 10'd105;
  localparam logic [CodeW-1:0]  KeyRight = 10'd106;
  localparam logic [ValueW-1:0] ValPress  = 2'd1;
  localparam logic [ValueW-1:0] ValRepeat = 2'd2;

  localparam logic [StepW-1:0] PanStepReset = 8'd16;

  typedef enum logic {
    OP_KEY   = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_ZOOM_IN   = 2'd1,
    EV_ZOOM_OUT  = 2'd2,
    EV_PANNED    = 2'd3
  } event_e;

endpackage

`default_nettype wire

// ===== rtl/zoom_window_address_control.sv =====
// Top level of the zoom window address control: key handling, panning and pixel address mapping.
//
// Usage. Items arrive on the slave stream (s_axis_*). tuser carries the item kind: 0 for a key
// event, 1 for a pixel query. A key event updates the menu-held flag, toggles zoom on L1 with
// the menu key held (recentring the window on entry) and pans the window on direction presses
// while zoom is on. A pixel query maps an output coordinate to the nearest-neighbour source
// coordinate inside the current window, clamped to the screen.
// Every item yields exactly one result item on the master stream (m_axis_*), in order.
// The pan step is written on the cfg_* channel, which is always ready; the user must write it
// only while no item is in flight, and the block itself does not enforce this.
// The item sits in the input register while the single pass of key logic or scaling multiply
// and clamp feeds the result register, from which the result is shown.
// Throughput is one item per clock while the receiver keeps taking results; the input
// register and result register form a two-stage pipeline, so a new item is taken while a
// finished result waits. When the receiver stalls, the result register holds; the input
// register fills behind it and s_axis_tready then drops until the result is taken.
// Reset clears both valid flags, drops zoom and the menu flag, recentres the window and loads the
// default pan step of 16 pixels.
`default_nettype none

module zoom_window_address_control
  import zwac_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input item stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata, from bit 0: key_code[9:0], key_value[11:10], out_x[21:12], out_y[30:22], zero pad
  input  wire logic [31:0] s_axis_tdata,
  // tuser: op (0 key event, 1 pixel query)
  input  wire logic        s_axis_tuser,
  // Result item stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata, from bit 0: zoom_on[0], event_res[2:1], src_x[12:3], src_y[21:13], zero pad
  output logic [23:0]      m_axis_tdata,
  // Pan step register write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i
);

  // Input register.
  logic              in_valid_q;
  op_e               op_q;
  logic [CodeW-1:0]  code_q;
  logic [ValueW-1:0] value_q;
  logic [XW-1:0]     ox_q;
  logic [YW-1:0]     oy_q;

  // Block state.
  logic [StepW-1:0]  pan_step_q;
  logic              menu_down_q, menu_down_d;
  logic              zoom_q, zoom_d;
  logic [XW-1:0]     win_x_q, win_x_d;
  logic [YW-1:0]     win_y_q, win_y_d;

  // Result register.
  logic              out_valid_q;
  logic              res_zoom_q;
  event_e            res_event_q, res_event_d;
  logic [XW-1:0]     res_x_q, res_x_d;
  logic [YW-1:0]     res_y_q, res_y_d;

  logic advance;
  logic take_in;

  // The input register moves on whenever the result register is free or being emptied.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign take_in       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Scaling: nearest-neighbour source offset by reciprocal multiplication.
  logic [XW+ScaleXW-1:0] prod_x;
  logic [YW+ScaleYW-1:0] prod_y;
  logic [SumW-1:0]       sum_x, sum_y;

  assign prod_x = (XW + ScaleXW)'(ox_q) * (XW + ScaleXW)'(ScaleX);
  assign prod_y = (YW + ScaleYW)'(oy_q) * (YW + ScaleYW)'(ScaleY);
  assign sum_x  = SumW'(prod_x >> ShiftX) + SumW'(win_x_q);
  assign sum_y  = SumW'(prod_y >> ShiftY) + SumW'(win_y_q);

  // Pan candidates, each clamped to the pan range.
  logic [XW:0]   left_x;
  logic [YW:0]   up_y;
  logic [XW-1:0] pan_left_x, pan_right_x;
  logic [YW-1:0] pan_up_y, pan_down_y;

  assign left_x = (XW + 1)'(win_x_q) + (XW + 1)'(pan_step_q);
  assign up_y   = (YW + 1)'(win_y_q) + (YW + 1)'(pan_step_q);

  always_comb begin
    pan_left_x  = (left_x > (XW + 1)'(MaxX)) ? XW'(MaxX) : left_x[XW-1:0];
    pan_up_y    = (up_y > (YW + 1)'(MaxY)) ? YW'(MaxY) : up_y[YW-1:0];
    pan_right_x = ((XW + 1)'(pan_step_q) > (XW + 1)'(win_x_q)) ? '0
                : XW'((XW + 1)'(win_x_q) - (XW + 1)'(pan_step_q));
    pan_down_y  = ((YW + 1)'(pan_step_q) > (YW + 1)'(win_y_q)) ? '0
                : YW'((YW + 1)'(win_y_q) - (YW + 1)'(pan_step_q));
  end

  // Single pass over the registered item.
  logic press;
  assign press = (value_q == ValPress);

  always_comb begin
    menu_down_d = menu_down_q;
    zoom_d      = zoom_q;
    win_x_d     = win_x_q;
    win_y_d     = win_y_q;
    res_event_d = EV_NONE;
    res_x_d     = '0;
    res_y_d     = '0;
    case (op_q)
      OP_QUERY: begin
        res_x_d = (sum_x > SumW'(ScreenWidth - 1)) ? XW'(ScreenWidth - 1) : sum_x[XW-1:0];
        res_y_d = (sum_y > SumW'(ScreenHeight - 1)) ? YW'(ScreenHeight - 1) : sum_y[YW-1:0];
      end
      OP_KEY: begin
        if (value_q != ValRepeat) begin
          if (code_q == KeyMenu) begin
            menu_down_d = press;
          end else if (code_q == KeyL1) begin
            if (press && menu_down_q) begin
              if (zoom_q) begin
                zoom_d      = 1'b0;
                res_event_d = EV_ZOOM_OUT;
              end else begin
                zoom_d      = 1'b1;
                win_x_d     = XW'(CentreX);
                win_y_d     = YW'(CentreY);
                res_event_d = EV_ZOOM_IN;
              end
            end
          end else if (zoom_q && press) begin
            if (code_q == KeyUp) begin
              win_y_d     = pan_up_y;
              res_event_d = EV_PANNED;
            end else if (code_q == KeyDown) begin
              win_y_d     = pan_down_y;
              res_event_d = EV_PANNED;
            end else if (code_q == KeyLeft) begin
              win_x_d     = pan_left_x;
              res_event_d = EV_PANNED;
            end else if (code_q == KeyRight) begin
              win_x_d     = pan_right_x;
              res_event_d = EV_PANNED;
            end
          end
        end
      end
      default: begin
        res_event_d = EV_NONE;
      end
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pan_step_q  <= PanStepReset;
      menu_down_q <= 1'b0;
      zoom_q      <= 1'b0;
      win_x_q     <= XW'(CentreX);
      win_y_q     <= YW'(CentreY);
    end else begin
      if (take_in) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        pan_step_q <= cfg_data_i;
      end
      if (advance) begin
        menu_down_q <= menu_down_d;
        zoom_q      <= zoom_d;
        win_x_q     <= win_x_d;
        win_y_q     <= win_y_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      op_q    <= op_e'(s_axis_tuser);
      code_q  <= s_axis_tdata[9:0];
      value_q <= s_axis_tdata[11:10];
      ox_q    <= s_axis_tdata[21:12];
      oy_q    <= s_axis_tdata[30:22];
    end
    if (advance) begin
      res_zoom_q  <= zoom_d;
      res_event_q <= res_event_d;
      res_x_q     <= res_x_d;
      res_y_q     <= res_y_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_y_q, res_x_q, res_event_q, res_zoom_q};

endmodule

`default_nettype wire
